>>> rtl/dltq_pkg.sv
// Shared types and constants for the delta list timeout queue.
`default_nettype none
package dltq_pkg;
  localparam int OpW    = 2;
  localparam int IdW    = 16;
  localparam int IvW    = 24;
  localparam int OwnW   = 8;
  localparam int KindW  = 3;
  localparam int DeltaW = 24;
  localparam int TpW    = 16;
  localparam int MaxRes = 16;

  localparam logic [OpW-1:0] OP_SCHED   = 2'd0;
  localparam logic [OpW-1:0] OP_UNSCHED = 2'd1;
  localparam logic [OpW-1:0] OP_TICK    = 2'd2;

  localparam logic [KindW-1:0] K_SCHED   = 3'd0;
  localparam logic [KindW-1:0] K_FULL    = 3'd1;
  localparam logic [KindW-1:0] K_REMOVED = 3'd2;
  localparam logic [KindW-1:0] K_NOTFND  = 3'd3;
  localparam logic [KindW-1:0] K_EXPIRED = 3'd4;
  localparam logic [KindW-1:0] K_NONE    = 3'd5;

  localparam logic [DeltaW-1:0] DeltaMax = {DeltaW{1'b1}};

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [OwnW-1:0]   owner;
    logic [DeltaW-1:0] delta;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic              ins;      // insert new entry at the selected cell
    logic              rem;      // remove entry at the selected cell
    logic              dec_head; // decrement head delta
    logic [DeltaW-1:0] rem_val;  // running remainder for insert
    entry_t            new_e;
  } cell_cmd_t;

  typedef struct packed {
    logic [OpW-1:0]  operation;
    logic [IdW-1:0]  timeout_id;
    logic [IvW-1:0]  interval;
    logic [OwnW-1:0] owner;
  } req_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [IdW-1:0]   timeout_id_res;
    logic [OwnW-1:0]  owner_res;
    logic             last;
  } rsp_t;
endpackage
`default_nettype wire

>>> rtl/dltq_if.sv
// Valid/ready channel interface carrying one beat of payload.
`default_nettype none
interface dltq_if #(parameter type T = logic) (input wire clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/delta_list_timeout_queue.sv
// Top level: delta list timeout queue with a chain of list cells.
//
// Channels: req (sink) carries operation, timeout_id, interval, owner; rsp
// (source) carries kind, timeout_id_res, owner_res, last. One beat on each
// channel transfers when valid and ready are high at a rising edge.
// tick_period is written through the APB port at byte address 0.
// After a request is accepted: a full table raises rsp valid at the accepting
// edge; unschedule walks the list; schedule runs the divider, then walks the
// list one entry at a time. The walk passes at most CAPACITY entries. A tick
// offers its first beat from S_TICK; further expiries follow after each beat is
// taken, at most 16 per tick.
// One item is worked at a time: the next request is accepted at the edge
// after the last result beat is taken.
// Reset empties the list and sets tick_period to 1. A stalled receiver
// holds the result register; the list and the next request wait until it drains.
`default_nettype none
module delta_list_timeout_queue #(
  parameter int CAPACITY = 16
) (
  input  wire         clk,
  input  wire         rst,
  dltq_if.sink        req,
  dltq_if.source      rsp,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [1:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dltq_pkg::*;
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_WALK = 3'd2,
                         S_DO = 3'd3, S_TICK = 3'd4;

  logic [TpW-1:0] tick_period;
  assign pready = 1'b1;
  always_comb prdata = (paddr == 2'd0) ? {16'd0, tick_period} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) tick_period <= TpW'(1);
    else if (psel && penable && pwrite && paddr == 2'd0) tick_period <= pwdata[TpW-1:0];
  end

  logic [2:0] state;
  req_t r;
  logic [CW-1:0] count;
  logic [4:0] nexp;
  logic out_v;
  rsp_t out_d;
  logic div_go, div_done;
  logic [IvW-1:0] quot;
  logic [CW-1:0] w;
  logic [IW-1:0] pos;
  logic hit;
  logic [DeltaW-1:0] rem_acc;

  logic [CAPACITY-1:0] cv;
  entry_t ce [CAPACITY];
  logic [CAPACITY-1:0] at_pos, past_pos, after_pos;
  cell_cmd_t cmd;
  logic do_ins, do_rem, do_dec;
  logic accept, sched_full, walk_stop, head_due, second_due, tick_last;
  entry_t cur;

  dltq_div u_div (.clk, .rst, .start(div_go), .dividend(r.interval),
                  .divisor(tick_period), .done(div_done), .quot(quot));

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      at_pos[i] = pos == IW'(i);
      past_pos[i] = IW'(i) > pos;
    end
  end
  assign after_pos = at_pos << 1;

  always_comb begin
    cmd = '0;
    cmd.ins = do_ins;
    cmd.rem = do_rem;
    cmd.dec_head = do_dec;
    cmd.rem_val = rem_acc;
    cmd.new_e.id = r.timeout_id;
    cmd.new_e.owner = r.owner;
    cmd.new_e.delta = rem_acc;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic pv, nv;
    entry_t pe, ne;
    if (g == 0) begin : g_first
      assign pv = 1'b0;
      assign pe = '0;
    end else begin : g_prev
      assign pv = cv[g-1];
      assign pe = ce[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign nv = 1'b0;
      assign ne = '0;
    end else begin : g_next
      assign nv = cv[g+1];
      assign ne = ce[g+1];
    end
    dltq_cell u_cell (
      .clk, .rst, .cmd,
      .at_pos(at_pos[g]), .past_pos(past_pos[g]), .after_pos(after_pos[g]),
      .is_head(g == 0),
      .prev_valid(pv), .prev_e(pe), .next_valid(nv), .next_e(ne),
      .valid(cv[g]), .e(ce[g])
    );
  end

  assign head_due = cv[0] && ce[0].delta == '0;
  if (CAPACITY > 1) begin : g_second
    assign second_due = cv[1] && ce[1].delta == '0;
  end else begin : g_no_second
    assign second_due = 1'b0;
  end
  assign tick_last = !second_due || nexp == 5'(MaxRes - 1);

  assign accept = req.valid && req.ready;
  assign sched_full = count == CW'(CAPACITY);

  always_comb begin
    cur = ce[w[IW-1:0]];
    if (w == count) walk_stop = 1'b1;
    else if (r.operation == OP_SCHED) walk_stop = cur.delta > rem_acc;
    else walk_stop = cur.id == r.timeout_id;
  end

  always_comb begin
    do_ins = (state == S_DO) && (r.operation == OP_SCHED);
    do_rem = ((state == S_DO) && (r.operation != OP_SCHED) && hit) ||
             ((state == S_TICK) && !out_v && head_due);
    do_dec = (state == S_TICK) && !out_v && !head_due;
  end

  assign req.ready = (state == S_IDLE) && !out_v;
  assign rsp.valid = out_v;
  assign rsp.data = out_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_v <= 1'b0;
      count <= '0;
      nexp <= '0;
      div_go <= 1'b0;
    end else begin
      div_go <= accept && req.data.operation == OP_SCHED && !sched_full;
      if (out_v && rsp.ready) out_v <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            r <= req.data;
            nexp <= '0;
            pos <= '0;
            w <= '0;
            hit <= 1'b0;
            case (req.data.operation)
              OP_SCHED: begin
                if (sched_full) begin
                  out_v <= 1'b1;
                  out_d <= '{K_FULL, req.data.timeout_id, req.data.owner, 1'b1};
                end else begin
                  state <= S_DIV;
                end
              end
              OP_UNSCHED: state <= S_WALK;
              OP_TICK: state <= S_TICK;
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            rem_acc <= quot;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_stop) begin
            pos <= w[IW-1:0];
            hit <= w != count;
            state <= S_DO;
          end else begin
            w <= w + CW'(1);
            if (r.operation == OP_SCHED) rem_acc <= rem_acc - cur.delta;
          end
        end
        S_DO: begin
          out_v <= 1'b1;
          state <= S_IDLE;
          if (r.operation == OP_SCHED) begin
            count <= count + CW'(1);
            out_d <= '{K_SCHED, r.timeout_id, r.owner, 1'b1};
          end else if (hit) begin
            count <= count - CW'(1);
            out_d <= '{K_REMOVED, r.timeout_id, ce[pos].owner, 1'b1};
          end else begin
            out_d <= '{K_NOTFND, r.timeout_id, '0, 1'b1};
          end
        end
        S_TICK: begin
          if (!out_v) begin
            out_v <= 1'b1;
            if (head_due) begin
              count <= count - CW'(1);
              nexp <= nexp + 5'd1;
              out_d <= '{K_EXPIRED, ce[0].id, ce[0].owner, tick_last};
              if (tick_last) state <= S_IDLE;
            end else begin
              out_d <= '{K_NONE, '0, '0, 1'b1};
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY)) else $error("count overflow");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> state == S_IDLE) else $error("ready outside idle");
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    $countones(cv) == int'(count)) else $error("valid bits disagree with count");
endmodule
`default_nettype wire

>>> rtl/dltq_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module dltq_div (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire [dltq_pkg::IvW-1:0]     dividend,
  input  wire [dltq_pkg::TpW-1:0]     divisor,
  output logic                         done,
  output logic [dltq_pkg::IvW-1:0]    quot
);
  import dltq_pkg::*;
  logic [TpW:0] part;
  logic [TpW-1:0] dvs;
  logic [4:0] cnt;
  logic busy;
  logic [TpW+1:0] trial;
  logic [TpW:0] sh;

  always_comb begin
    sh = {part[TpW-1:0], quot[IvW-1]};
    trial = {1'b0, sh} - {2'b0, dvs};
  end

  always_ff @(posedge clk) begin
    done <= !rst && busy && !start && (cnt == 5'd1);
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 5'(IvW);
      part <= '0;
      quot <= dividend;
      dvs <= (divisor == '0) ? TpW'(1) : divisor;
    end else if (busy) begin
      if (!trial[TpW+1]) begin
        part <= trial[TpW:0];
        quot <= {quot[IvW-2:0], 1'b1};
      end else begin
        part <= sh;
        quot <= {quot[IvW-2:0], 1'b0};
      end
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/dltq_cell.sv
// One slot of the sorted delta list; shifts with its neighbors.
`default_nettype none
module dltq_cell (
  input  wire                    clk,
  input  wire                    rst,
  input  dltq_pkg::cell_cmd_t    cmd,
  input  wire                    at_pos,     // this cell is the selected slot
  input  wire                    past_pos,   // this cell lies beyond the selected slot
  input  wire                    after_pos,  // this cell directly follows the selected slot
  input  wire                    is_head,
  input  wire                    prev_valid,
  input  dltq_pkg::entry_t       prev_e,
  input  wire                    next_valid,
  input  dltq_pkg::entry_t       next_e,
  output logic                   valid,
  output dltq_pkg::entry_t       e
);
  import dltq_pkg::*;
  logic [DeltaW:0] sum;
  logic valid_next;
  entry_t e_next;

  assign sum = {1'b0, next_e.delta} + {1'b0, e.delta};

  always_comb begin
    valid_next = valid;
    e_next = e;
    if (cmd.ins) begin
      if (at_pos) begin
        valid_next = 1'b1;
        e_next = cmd.new_e;
      end else if (past_pos) begin
        valid_next = prev_valid;
        e_next = prev_e;
        if (after_pos) e_next.delta = prev_e.delta - cmd.rem_val;
      end
    end else if (cmd.rem) begin
      if (at_pos || past_pos) begin
        valid_next = next_valid;
        e_next = next_e;
        if (at_pos && next_valid) e_next.delta = sum[DeltaW] ? DeltaMax : sum[DeltaW-1:0];
      end
    end else if (cmd.dec_head && is_head && valid) begin
      e_next.delta = e.delta - DeltaW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    e <= e_next;
  end
endmodule
`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the delta list timeout queue.
`timescale 1ns / 1ps
module testbench;
  import dltq_pkg::*;

  localparam int Cap = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  dltq_if #(.T(req_t)) req_ch (clk);
  dltq_if #(.T(rsp_t)) rsp_ch (clk);

  delta_list_timeout_queue #(.CAPACITY(Cap)) u_top (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [IdW-1:0]    q_id    [Cap];
  logic [OwnW-1:0]   q_own   [Cap];
  logic [DeltaW-1:0] q_delta [Cap];
  int unsigned       q_count;
  logic [TpW-1:0]    tick_len;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic stall_on = 1'b0;
  int   errors = 0;
  int   n_rsp = 0, n_expired = 0, n_full = 0;
  int   n_items = 0;
  logic [IdW-1:0] used_ids[$];

  function automatic rsp_t mk(logic [KindW-1:0] k, logic [IdW-1:0] id,
                              logic [OwnW-1:0] o, logic l);
    rsp_t r;
    r.kind = k; r.timeout_id_res = id; r.owner_res = o; r.last = l;
    return r;
  endfunction

  task automatic expect_beat(rsp_t b);
    expected_rsps.insert(expected_rsps.size(), b);
  endtask

  task automatic drop_entry(int unsigned pos);
    for (int unsigned i = pos; i + 1 < q_count; i++) begin
      q_id[i] = q_id[i+1]; q_own[i] = q_own[i+1]; q_delta[i] = q_delta[i+1];
    end
    q_count--;
  endtask

  task automatic predict_timeouts(req_t r);
    logic [31:0] divisor;
    logic [31:0] remain;
    logic [31:0] sum;
    int unsigned pos;
    int n;
    bit hit;
    rsp_t tail;
    n = 0;
    hit = 0;
    case (r.operation)
      OP_SCHED: begin
        if (q_count >= Cap) begin
          expect_beat(mk(K_FULL, r.timeout_id, r.owner, 1'b1));
        end else begin
          divisor = (tick_len == 0) ? 32'd1 : 32'(tick_len);
          remain = 32'(r.interval) / divisor;
          pos = q_count;
          for (int unsigned i = 0; i < q_count; i++) begin
            if (32'(q_delta[i]) > remain) begin
              pos = i;
              break;
            end
            remain -= 32'(q_delta[i]);
          end
          if (pos < q_count) q_delta[pos] = q_delta[pos] - remain[DeltaW-1:0];
          for (int unsigned i = q_count; i > pos; i--) begin
            q_id[i] = q_id[i-1]; q_own[i] = q_own[i-1]; q_delta[i] = q_delta[i-1];
          end
          q_id[pos] = r.timeout_id;
          q_own[pos] = r.owner;
          q_delta[pos] = remain[DeltaW-1:0];
          q_count++;
          expect_beat(mk(K_SCHED, r.timeout_id, r.owner, 1'b1));
        end
      end
      OP_UNSCHED: begin
        for (int unsigned i = 0; i < q_count; i++) begin
          if (q_id[i] == r.timeout_id) begin
            if (i + 1 < q_count) begin
              sum = 32'(q_delta[i+1]) + 32'(q_delta[i]);
              q_delta[i+1] = (sum > 32'(DeltaMax)) ? DeltaMax : sum[DeltaW-1:0];
            end
            expect_beat(mk(K_REMOVED, r.timeout_id, q_own[i], 1'b1));
            drop_entry(i);
            hit = 1;
            break;
          end
        end
        if (!hit) expect_beat(mk(K_NOTFND, r.timeout_id, '0, 1'b1));
      end
      OP_TICK: begin
        if (q_count == 0 || q_delta[0] != 0) begin
          if (q_count != 0) q_delta[0] = q_delta[0] - DeltaW'(1);
          expect_beat(mk(K_NONE, '0, '0, 1'b1));
        end else begin
          while (q_count > 0 && q_delta[0] == 0 && n < MaxRes) begin
            expect_beat(mk(K_EXPIRED, q_id[0], q_own[0], 1'b0));
            drop_entry(0);
            n++;
          end
          tail = expected_rsps.pop_back();
          tail.last = 1'b1;
          expect_beat(tail);
        end
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid) predict_timeouts(req_ch.data);
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req_ch.valid <= 1'b1;
        req_ch.data <= pending_reqs.pop_front();
        n_items++;
      end else begin
        req_ch.valid <= 1'b0;
        req_ch.data <= req_t'($bits(req_t)'({$urandom, $urandom}));
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_t e;
        n_rsp++;
        if (expected_rsps.size() == 0) begin
          $error("unexpected beat kind=%0d id=%0h", rsp_ch.data.kind,
                 rsp_ch.data.timeout_id_res);
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          if (e.kind == K_EXPIRED) n_expired++;
          if (e.kind == K_FULL) n_full++;
          if (rsp_ch.data.kind !== e.kind) begin
            $error("kind exp %0d got %0d", e.kind, rsp_ch.data.kind); errors++;
          end
          if (rsp_ch.data.timeout_id_res !== e.timeout_id_res) begin
            $error("timeout_id_res exp %0h got %0h", e.timeout_id_res,
                   rsp_ch.data.timeout_id_res); errors++;
          end
          if (rsp_ch.data.owner_res !== e.owner_res) begin
            $error("owner_res exp %0h got %0h", e.owner_res, rsp_ch.data.owner_res);
            errors++;
          end
          if (rsp_ch.data.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, rsp_ch.data.last); errors++;
          end
        end
      end
      if (stall_on) begin
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic cfg_write(logic [TpW-1:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    tick_len = v;
    @(posedge clk);
    if (prdata[TpW-1:0] !== v) begin
      $error("tick_period exp %0h got %0h", v, prdata[TpW-1:0]); errors++;
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic add(logic [OpW-1:0] op, logic [IdW-1:0] id, logic [IvW-1:0] iv,
                     logic [OwnW-1:0] o);
    req_t r;
    r.operation = op; r.timeout_id = id; r.interval = iv; r.owner = o;
    pending_reqs.insert(pending_reqs.size(), r);
    if (op == OP_SCHED) used_ids.insert(used_ids.size(), id);
  endtask

  // mostly well-formed traffic: schedule new ids (sometimes reused), unschedule mostly known ids, tick often
  task automatic add_random(int cnt);
    int pick;
    for (int k = 0; k < cnt; k++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        add(OP_SCHED, (used_ids.size() > 0 && $urandom_range(9) == 0) ?
            used_ids[$urandom_range(used_ids.size()-1)] : 16'($urandom),
            ($urandom_range(7) == 0) ? 24'($urandom) : 24'($urandom_range(40)),
            8'($urandom));
      end else if (pick < 55) begin
        add(OP_UNSCHED, (used_ids.size() > 0 && $urandom_range(3) != 0) ?
            used_ids[$urandom_range(used_ids.size()-1)] : 16'($urandom),
            24'($urandom), 8'($urandom));
      end else if (pick < 97) begin
        add(OP_TICK, 16'($urandom), 24'($urandom), 8'($urandom));
      end else begin
        add(2'd3, 16'($urandom), 24'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    q_count = 0;
    tick_len = 16'd1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty tick, not found, fill to full, burst expiry, wraps
    add(OP_TICK, 16'h0, 24'h0, 8'h0);
    add(OP_UNSCHED, 16'hFFFF, 24'hFFFFFF, 8'hFF);
    for (int i = 0; i < Cap; i++)
      add(OP_SCHED, 16'(i * 16'h1111), 24'(i % 3), 8'(8'hF0 + i));
    add(OP_SCHED, 16'hFFFF, 24'hFFFFFF, 8'hFF);
    add(OP_UNSCHED, 16'h1111, 24'h0, 8'h0);
    add(OP_SCHED, 16'hABCD, 24'hFFFFFF, 8'h5A);
    add(OP_TICK, 16'h0, 24'h0, 8'h0);
    add(OP_TICK, 16'h0, 24'h0, 8'h0);
    add(OP_TICK, 16'h0, 24'h0, 8'h0);
    add(2'd3, 16'hFFFF, 24'hFFFFFF, 8'hFF);
    drain();

    cfg_write(16'd0);
    add(OP_SCHED, 16'h0001, 24'd5, 8'h01);
    add_random(60);
    drain();

    cfg_write(16'hFFFF);
    send_idle_pct = 81;
    add(OP_SCHED, 16'h0002, 24'hFFFFFF, 8'h02);
    add_random(60);
    drain();

    cfg_write(16'd3);
    send_idle_pct = 0;
    recv_stall_pct = 81;
    add_random(60);
    drain();

    cfg_write(16'd1);
    send_idle_pct = 24;
    recv_stall_pct = 24;
    add_random(60);
    drain();

    // long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        stall_on <= 1'b1;
        repeat (300) @(posedge clk);
        stall_on <= 1'b0;
      end
    join_none
    add_random(40);
    drain();

    $display("Covered %0d items, %0d result beats (%0d expiries, %0d table-full)",
             n_items, n_rsp, n_expired, n_full);
    $display("Tick periods 0, 1, 3 and 65535 under idle, stall and hold-off phases");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
